// ----- sv/aes_cbc_cipher_defines.svh -----
// Assertion macros for the AES CBC cipher block.
// Included by the top level; no other dependencies.
`ifndef AES_CBC_CIPHER_DEFINES_SVH
`define AES_CBC_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define AESCBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes_cbc_cipher: check failed");
`define AESCBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes_cbc_cipher: check failed");
`else
`define AESCBC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AESCBC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/aescbc_pkg.sv -----
// Types, constants and round functions shared by the AES CBC cipher block.
// No dependencies.
package aescbc_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        start_of_message;
  } blk_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } res_t;

  typedef enum logic [3:0] {
    REG_KEY0     = 4'd0,
    REG_KEY1     = 4'd1,
    REG_KEY2     = 4'd2,
    REG_KEY3     = 4'd3,
    REG_KEY_SIZE = 4'd4,
    REG_IV_HIGH  = 4'd5,
    REG_IV_LOW   = 4'd6,
    REG_DECRYPT  = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_INIT  = 2'd1,
    OP_ROUND = 2'd2,
    OP_LAST  = 2'd3
  } op_t;

  localparam int ROW_W = 4;
  localparam int IDX_W = 6;

  typedef struct packed {
    logic             take;
    logic             exp_en;
    logic             exp_key;
    logic             exp_rot;
    logic             exp_sub;
    logic [IDX_W-1:0] exp_idx;
    logic [ROW_W-1:0] rd_row;
    op_t              op;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] ks;
    logic       dec;
    logic       res_free;
  } stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef logic [255:0][7:0] byte_map_t;

  function automatic byte_map_t inv_map();
    byte_map_t m;
    m = '0;
    for (int i = 0; i < 256; i++) m[SBOX[i]] = 8'(i);
    return m;
  endfunction

  localparam byte_map_t INV_SBOX = inv_map();

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [3:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int j = 0; j < 4; j++) begin
      if (b[j]) r = r ^ x;
      x = xtime(x);
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [3:0] nrounds(logic [1:0] ks);
    return 4'd10 + {1'b0, ks, 1'b0};
  endfunction

  function automatic logic [3:0] nkeywords(logic [1:0] ks);
    return 4'd4 + {1'b0, ks, 1'b0};
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s, logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv)
          t[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c-r)&3)) -: 8]];
        else
          t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(logic [127:0] s, logic inv);
    logic [127:0] t;
    logic [3:0]   m [4];
    logic [7:0]   acc;
    t = '0;
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2; m[1] = 4'd3; m[2] = 4'd1; m[3] = 4'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc = acc ^ gmul(s[127-8*(k+4*c) -: 8], m[(k-r)&3]);
        t[127-8*(r+4*c) -: 8] = acc;
      end
    end
    return t;
  endfunction

endpackage

// ----- sv/aes_cbc_cipher.sv -----
// Top level of the AES CBC cipher: sequencer plus datapath.
// Depends on aescbc_pkg, aescbc_ctrl, aescbc_dp and aes_cbc_cipher_defines.svh.
//
//   channel | handshake            | payload
//   blk     | blk_valid, blk_stall | blk (block_high, block_low, start_of_message)
//   res     | res_valid, res_stall | res (out_high, out_low)
//   cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// Blocks are taken one at a time; each runs Nr rounds after the key addition (Nr = 10, 12, 14):
// one AES round per cycle through a single round unit fed by the round-key memory.
// A start-of-message block first runs key expansion, one word per cycle, 4*(Nr+1) words in all.
// rst is synchronous; it clears control, configuration and the chain value.
// The result register frees the core; a held result stalls only the final hand-off.
`include "aes_cbc_cipher_defines.svh"
module aes_cbc_cipher #(
  parameter int ROUND_KEY_WORDS = 60
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             blk_valid,
  output logic             blk_stall,
  input  aescbc_pkg::blk_t blk,
  output logic             res_valid,
  input  logic             res_stall,
  output aescbc_pkg::res_t res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  aescbc_pkg::cmd_t  cmd;
  aescbc_pkg::stat_t stat;
  logic              busy;

  assign blk_stall = busy || rst;
  assign cfg_ready = 1'b1;

  aescbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .sof       (blk.start_of_message),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  aescbc_dp #(
    .ROUND_KEY_WORDS (ROUND_KEY_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk       (blk),
    .res_stall (res_stall),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

  `AESCBC_ASSERT_IMP(a_fin_free, clk, rst, cmd.finish, stat.res_free)
  `AESCBC_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.take, cmd.exp_en, cmd.finish}))
  `AESCBC_ASSERT_IMP(a_exp_quiet, clk, rst, cmd.exp_en, cmd.op == aescbc_pkg::OP_IDLE)
  `AESCBC_ASSERT_NXT(a_take_busy, clk, rst, cmd.take, blk_stall)

endmodule

// ----- sv/aescbc_ctrl.sv -----
// Sequencer for the AES CBC cipher: key expansion, round steps, result hand-off.
// Depends on aescbc_pkg.
module aescbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               blk_valid,
  input  logic               sof,
  input  aescbc_pkg::stat_t  stat,
  output logic               busy,
  output aescbc_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXPAND = 5'b00010,
    S_KEY    = 5'b00100,
    S_RUN    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t                       state, state_next;
  logic [aescbc_pkg::IDX_W-1:0] idx;
  logic [3:0]                   modc;
  logic [3:0]                   rnd;
  logic [3:0]                   nr, nk, rnd_inc;
  logic [aescbc_pkg::IDX_W-1:0] last_idx;

  assign nr       = aescbc_pkg::nrounds(stat.ks);
  assign nk       = aescbc_pkg::nkeywords(stat.ks);
  assign last_idx = {nr, 2'b11};
  assign rnd_inc  = rnd + 4'd1;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.op      = aescbc_pkg::OP_IDLE;
    cmd.exp_idx = idx;
    unique case (state)
      S_IDLE: begin
        if (blk_valid) begin
          cmd.take   = 1'b1;
          state_next = sof ? S_EXPAND : S_KEY;
        end
      end
      S_EXPAND: begin
        cmd.exp_en  = 1'b1;
        cmd.exp_key = ({2'b00, idx} < {4'd0, nk}) ? 1'b1 : 1'b0;
        cmd.exp_rot = !cmd.exp_key && (modc == 4'd0);
        cmd.exp_sub = !cmd.exp_key && (stat.ks == 2'd2) && (modc == 4'd4);
        if (idx == last_idx) state_next = S_KEY;
      end
      S_KEY: begin
        cmd.rd_row = stat.dec ? nr : 4'd0;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.rd_row = stat.dec ? nr - rnd_inc : rnd_inc;
        if (rnd == 4'd0)     cmd.op = aescbc_pkg::OP_INIT;
        else if (rnd == nr)  cmd.op = aescbc_pkg::OP_LAST;
        else                 cmd.op = aescbc_pkg::OP_ROUND;
        if (rnd == nr) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.res_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      modc  <= '0;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        idx  <= '0;
        modc <= '0;
      end else if (cmd.exp_en) begin
        idx  <= idx + 1'b1;
        modc <= (modc == nk - 4'd1) ? 4'd0 : modc + 4'd1;
      end
      if (state == S_KEY) rnd <= '0;
      else if (state == S_RUN) rnd <= rnd_inc;
    end
  end

endmodule

// ----- sv/aescbc_dp.sv -----
// Datapath for the AES CBC cipher: registers, key schedule, round-key memory,
// round unit, chain value and result register. Depends on aescbc_pkg.
module aescbc_dp #(
  parameter int ROUND_KEY_WORDS = 60
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [3:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  aescbc_pkg::blk_t  blk,
  input  logic              res_stall,
  input  aescbc_pkg::cmd_t  cmd,
  output aescbc_pkg::stat_t stat,
  output logic              res_valid,
  output aescbc_pkg::res_t  res
);

  localparam int ROWS = (ROUND_KEY_WORDS + 3) / 4;
  localparam int RAW  = $clog2(ROWS);

  logic [255:0]   key_all;
  logic [1:0]     key_size;
  logic [127:0]   iv;
  logic           decrypt_mode;
  logic [1:0]     ks;
  logic [127:0]   chain;
  logic [127:0]   inbuf;
  logic [127:0]   state;
  logic [7:0]     rcon;
  logic [31:0]    win [8];
  logic [95:0]    row_buf;
  logic [127:0]   row_new;
  logic [127:0]   rk_mem [ROWS];
  logic [127:0]   rk_q;
  logic [31:0]    t_word, new_word;
  logic [3:0]     nk;
  logic [127:0]   enc_ss, dec_ss;

  assign nk = aescbc_pkg::nkeywords(ks);

  always_comb begin
    t_word = win[0];
    if (cmd.exp_rot)
      t_word = aescbc_pkg::sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h0};
    else if (cmd.exp_sub)
      t_word = aescbc_pkg::sub_word(win[0]);
    if (cmd.exp_key)
      new_word = key_all[255 - 32*cmd.exp_idx[2:0] -: 32];
    else
      new_word = win[nk[2:0] - 3'd1] ^ t_word;
  end

  // drop words beyond the end of the store
  always_comb begin
    row_new = {row_buf, new_word};
    for (int j = 0; j < 4; j++) begin
      if (32'({cmd.exp_idx[5:2], 2'b00}) + j >= ROUND_KEY_WORDS)
        row_new[127-32*j -: 32] = '0;
    end
  end

  assign enc_ss = aescbc_pkg::sub_shift(state, 1'b0);
  assign dec_ss = aescbc_pkg::sub_shift(state, 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_all      <= '0;
      key_size     <= '0;
      iv           <= '0;
      decrypt_mode <= 1'b0;
      ks           <= '0;
      chain        <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          aescbc_pkg::REG_KEY0:     key_all[255:192] <= cfg_data;
          aescbc_pkg::REG_KEY1:     key_all[191:128] <= cfg_data;
          aescbc_pkg::REG_KEY2:     key_all[127:64]  <= cfg_data;
          aescbc_pkg::REG_KEY3:     key_all[63:0]    <= cfg_data;
          aescbc_pkg::REG_KEY_SIZE: key_size         <= cfg_data[1:0];
          aescbc_pkg::REG_IV_HIGH:  iv[127:64]       <= cfg_data;
          aescbc_pkg::REG_IV_LOW:   iv[63:0]         <= cfg_data;
          aescbc_pkg::REG_DECRYPT:  decrypt_mode     <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.take && blk.start_of_message) begin
        chain <= iv;
        ks    <= (key_size == 2'd3) ? 2'd2 : key_size;
      end
      if (cmd.finish) begin
        chain <= decrypt_mode ? inbuf : state;
      end
      if (cmd.finish) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      inbuf <= {blk.block_high, blk.block_low};
      rcon  <= 8'h01;
    end
    if (cmd.exp_en) begin
      win[0]  <= new_word;
      for (int i = 1; i < 8; i++) win[i] <= win[i-1];
      row_buf <= {row_buf[63:0], new_word};
      if (cmd.exp_rot) rcon <= aescbc_pkg::xtime(rcon);
      if (cmd.exp_idx[1:0] == 2'b11 && 32'(cmd.exp_idx[5:2]) < ROWS)
        rk_mem[cmd.exp_idx[RAW+1:2]] <= row_new;
    end
    if (32'(cmd.rd_row) < ROWS) rk_q <= rk_mem[cmd.rd_row[RAW-1:0]];
    else rk_q <= '0;
    unique case (cmd.op)
      aescbc_pkg::OP_IDLE: ;
      aescbc_pkg::OP_INIT:
        state <= decrypt_mode ? inbuf ^ rk_q : inbuf ^ chain ^ rk_q;
      aescbc_pkg::OP_ROUND:
        state <= decrypt_mode ? aescbc_pkg::mix(dec_ss ^ rk_q, 1'b1)
                              : aescbc_pkg::mix(enc_ss, 1'b0) ^ rk_q;
      aescbc_pkg::OP_LAST:
        state <= decrypt_mode ? dec_ss ^ rk_q : enc_ss ^ rk_q;
      default: ;
    endcase
    if (cmd.finish) res <= decrypt_mode ? state ^ chain : state;
  end

  assign stat.ks       = ks;
  assign stat.dec      = decrypt_mode;
  assign stat.res_free = !res_valid || !res_stall;

endmodule

// ----- tb/sv/aes_cbc_cipher_tb.sv -----
// Testbench for the AES CBC cipher: directed and random CBC messages under all key sizes.
// Holds its own AES/CBC predictor and compares every result word; depends on aescbc_pkg.
`timescale 1ns / 1ps
module aes_cbc_cipher_tb;

  logic             clk;
  logic             rst;
  logic             blk_valid;
  logic             blk_stall;
  aescbc_pkg::blk_t blk;
  logic             res_valid;
  logic             res_stall;
  aescbc_pkg::res_t res;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [3:0]       cfg_index;
  logic [63:0]      cfg_data;

  aes_cbc_cipher dut (.*);

  logic [7:0]       fwd_sbox [256];
  logic [7:0]       rev_sbox [256];
  logic [63:0]      key_reg [4];
  logic [1:0]       size_reg;
  logic [63:0]      iv_reg [2];
  logic             dec_reg;
  logic [127:0]     chain;
  logic [31:0]      sched [60];
  int               rounds;
  aescbc_pkg::res_t expected_q [$];
  int               errors;
  int               send_idle;
  int               recv_idle;
  longint           cycles;

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = xt(a);
    end
    return r;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int nk;
    int total;
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    int ks;
    ks = (size_reg >= 2) ? 2 : size_reg;
    nk = 4 + 2 * ks;
    rounds = 10 + 2 * ks;
    total = 4 * (rounds + 1);
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xt(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int i = 0; i < total; i++) sched[i] = w[i];
  endtask

  function automatic logic [127:0] round_key(int r);
    return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function automatic logic [7:0] sb(logic [127:0] s, int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] shift_sub(logic [127:0] s, bit inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(r+4*((c+r)&3)) -: 8] = rev_sbox[sb(s, r+4*c)];
        else t[127-8*(r+4*c) -: 8] = fwd_sbox[sb(s, r+4*((c+r)&3))];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
    logic [127:0] t;
    logic [7:0] m [4];
    logic [7:0] acc;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(sb(s, k+4*c), m[(k-r)&3]);
        t[127-8*(r+4*c) -: 8] = acc;
      end
    return t;
  endfunction

  function automatic logic [127:0] encipher_block(logic [127:0] s);
    s ^= round_key(0);
    for (int r = 1; r < rounds; r++) s = mix_cols(shift_sub(s, 0), 0) ^ round_key(r);
    return shift_sub(s, 0) ^ round_key(rounds);
  endfunction

  function automatic logic [127:0] decipher_block(logic [127:0] s);
    s ^= round_key(rounds);
    for (int r = rounds - 1; r >= 1; r--) s = mix_cols(shift_sub(s, 1) ^ round_key(r), 1);
    return shift_sub(s, 1) ^ round_key(0);
  endfunction

  task automatic predict_block(aescbc_pkg::blk_t b);
    logic [127:0] d;
    logic [127:0] o;
    aescbc_pkg::res_t e;
    if (b.start_of_message) begin
      chain = {iv_reg[0], iv_reg[1]};
      expand_schedule();
    end
    d = {b.block_high, b.block_low};
    if (dec_reg) begin
      o = decipher_block(d) ^ chain;
      chain = d;
    end else begin
      o = encipher_block(d ^ chain);
      chain = o;
    end
    e.out_high = o[127:64];
    e.out_low = o[63:0];
    expected_q.push_back(e);
  endtask

  task automatic write_reg(aescbc_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aescbc_pkg::REG_KEY0, aescbc_pkg::REG_KEY1,
      aescbc_pkg::REG_KEY2, aescbc_pkg::REG_KEY3: key_reg[idx] = val;
      aescbc_pkg::REG_KEY_SIZE: size_reg = val[1:0];
      aescbc_pkg::REG_IV_HIGH: iv_reg[0] = val;
      aescbc_pkg::REG_IV_LOW: iv_reg[1] = val;
      aescbc_pkg::REG_DECRYPT: dec_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit som);
    aescbc_pkg::blk_t b;
    b.block_high = hi;
    b.block_low = lo;
    b.start_of_message = som;
    while ($urandom_range(99) < send_idle) begin
      blk_valid <= 1'b0;
      @(posedge clk);
    end
    blk_valid <= 1'b1;
    blk <= b;
    do @(posedge clk); while (blk_stall);
    predict_block(b);
  endtask

  task automatic drain();
    blk_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_keys(logic [1:0] ks, bit dec, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    drain();
    write_reg(aescbc_pkg::REG_KEY0, k0);
    write_reg(aescbc_pkg::REG_KEY1, k1);
    write_reg(aescbc_pkg::REG_KEY2, k2);
    write_reg(aescbc_pkg::REG_KEY3, k3);
    write_reg(aescbc_pkg::REG_KEY_SIZE, {62'd0, ks});
    write_reg(aescbc_pkg::REG_IV_HIGH, {$urandom, $urandom});
    write_reg(aescbc_pkg::REG_IV_LOW, {$urandom, $urandom});
    write_reg(aescbc_pkg::REG_DECRYPT, {63'd0, dec});
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_fips_vectors();
    set_keys(2'd0, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
    write_reg(aescbc_pkg::REG_IV_HIGH, 64'h0);
    write_reg(aescbc_pkg::REG_IV_LOW, 64'h0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    send_block(64'h0, 64'h0, 1'b0);
    send_block('1, '1, 1'b0);
    set_keys(2'd1, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    set_keys(2'd2, 1'b1, '1, '1, '1, '1);
    send_block('1, '1, 1'b1);
    send_block(64'h0, 64'h0, 1'b0);
  endtask

  task automatic test_unused_size_code();
    set_keys(2'd3, 1'b0, rnd64(), rnd64(), rnd64(), rnd64());
    send_block(rnd64(), rnd64(), 1'b1);
    send_block(rnd64(), rnd64(), 1'b0);
    drain();
    write_reg(aescbc_pkg::REG_DECRYPT, 64'd1);
    send_block(rnd64(), rnd64(), 1'b1);
  endtask

  task automatic test_mid_message_writes();
    set_keys(2'd0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0);
    send_block(rnd64(), rnd64(), 1'b1);
    drain();
    write_reg(aescbc_pkg::REG_KEY0, rnd64());
    write_reg(aescbc_pkg::REG_KEY_SIZE, 64'd2);
    write_reg(aescbc_pkg::REG_IV_HIGH, rnd64());
    write_reg(aescbc_pkg::REG_DECRYPT, 64'd1);
    send_block(rnd64(), rnd64(), 1'b0);
    send_block(rnd64(), rnd64(), 1'b1);
    drain();
    write_reg(aescbc_pkg::REG_DECRYPT, 64'd0);
    send_block(rnd64(), rnd64(), 1'b0);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= 4'd9;
    cfg_data <= rnd64();
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    send_block(rnd64(), rnd64(), 1'b0);
  endtask

  task automatic test_random_messages(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      set_keys(2'($urandom_range(3)), 1'($urandom_range(1)),
               rnd64(), rnd64(), rnd64(), rnd64());
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        send_block(rnd64(), rnd64(), i == 0 || $urandom_range(19) == 0);
        if ($urandom_range(49) == 0) begin
          drain();
          write_reg(aescbc_pkg::REG_DECRYPT, {63'd0, ~dec_reg});
        end
      end
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      res_stall <= ($urandom_range(99) < recv_idle);
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h_%h", res.out_high, res.out_low);
          errors++;
        end else begin
          if (res.out_high !== expected_q[0].out_high) begin
            $error("out_high expected %h actual %h", expected_q[0].out_high, res.out_high);
            errors++;
          end
          if (res.out_low !== expected_q[0].out_low) begin
            $error("out_low expected %h actual %h", expected_q[0].out_low, res.out_low);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("aes_cbc_cipher verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      fwd_sbox[i] = aescbc_pkg::SBOX[i];
      rev_sbox[aescbc_pkg::SBOX[i]] = 8'(i);
    end
    errors = 0;
    cycles = 0;
    send_idle = 25;
    recv_idle = 78;
    key_reg = '{64'h0, 64'h0, 64'h0, 64'h0};
    size_reg = 2'd0;
    iv_reg = '{64'h0, 64'h0};
    dec_reg = 1'b0;
    chain = '0;
    rounds = 10;
    rst = 1'b1;
    blk_valid = 1'b0;
    blk = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_fips_vectors();
    test_unused_size_code();
    test_mid_message_writes();
    test_random_messages(360);
    send_idle = 78;
    recv_idle = 25;
    test_random_messages(360);
    send_idle = 0;
    recv_idle = 0;
    test_random_messages(360);
    drain();
    if (errors == 0) begin
      $display("aes_cbc_cipher verification clean");
    end else begin
      $display("aes_cbc_cipher verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+sv
sv/aescbc_pkg.sv
sv/aescbc_ctrl.sv
sv/aescbc_dp.sv
sv/aes_cbc_cipher.sv
tb/sv/aes_cbc_cipher_tb.sv
